// ===== rtl/dvdd_pkg.sv =====
// Shared types, calendar tables and constant-division helpers for the date block.
package dvdd_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int SERIAL_W = 23;
    localparam int DIFF_W   = 23;
    localparam int ORDER_W  = 2;

    localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'b11;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'b00;
    localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'b01;

    // Reciprocal of 25 scaled by 2^15; exact for quotients of 12-bit values.
    localparam logic [10:0] RECIP_25 = 11'd1311;
    localparam int          RECIP_SH = 15;

    typedef struct packed {
        logic                valid;
        logic [SERIAL_W-1:0] serial;
    } date_info_t;

    // Year divided by 100, as (year / 4) / 25 through a reciprocal multiply.
    function automatic logic [7:0] div100(input logic [YEAR_W-1:0] year);
        logic [11:0] quarter;
        logic [22:0] prod;
        begin
            quarter = year[YEAR_W-1:2];
            prod    = 23'(quarter) * 23'(RECIP_25);
            div100  = prod[RECIP_SH+7:RECIP_SH];
        end
    endfunction

    // Length of a month in a common year; months outside 1..12 count 31.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month);
        begin
            case (month)
                4'd2:                         month_days = 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:      month_days = 5'd30;
                default:                      month_days = 5'd31;
            endcase
        end
    endfunction

    // Days of the whole months before the given month in a common year.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
        begin
            case (month)
                4'd0:    days_before = 9'd0;
                4'd1:    days_before = 9'd0;
                4'd2:    days_before = 9'd31;
                4'd3:    days_before = 9'd59;
                4'd4:    days_before = 9'd90;
                4'd5:    days_before = 9'd120;
                4'd6:    days_before = 9'd151;
                4'd7:    days_before = 9'd181;
                4'd8:    days_before = 9'd212;
                4'd9:    days_before = 9'd243;
                4'd10:   days_before = 9'd273;
                4'd11:   days_before = 9'd304;
                4'd12:   days_before = 9'd334;
                4'd13:   days_before = 9'd365;
                4'd14:   days_before = 9'd396;
                default: days_before = 9'd427;
            endcase
        end
    endfunction

endpackage

// ===== rtl/dvdd_date_unit.sv =====
// Validity check and serial day number for one calendar date.
module dvdd_date_unit
    import dvdd_pkg::*;
(
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output date_info_t         info
);

    logic [7:0]          hund_y;
    logic                div4_y;
    logic                div100_y;
    logic                leap;
    logic [YEAR_W-1:0]   prev;
    logic [7:0]          hund_p;
    logic [11:0]         leaps_before;
    logic [DAY_W-1:0]    month_len;
    logic [SERIAL_W-1:0] year_days;
    logic [9:0]          month_off;

    always_comb
    begin
        hund_y   = div100(year);
        div4_y   = (year[1:0] == 2'b00);
        div100_y = div4_y && ((10'(hund_y) * 10'd25) == 10'(year[YEAR_W-1:2]) ) ;
        leap     = div100_y ? (hund_y[1:0] == 2'b00) : div4_y;

        // Leap years in 1 .. year-1; none before year zero.
        prev   = year - YEAR_W'(1);
        hund_p = div100(prev);
        if (year == '0)
        begin
            leaps_before = '0;
        end
        else
        begin
            leaps_before = prev[YEAR_W-1:2] - 12'(hund_p) + 12'(hund_p[7:2]);
        end

        month_len = month_days(month);
        if (month == 4'd2 && leap)
        begin
            month_len = 5'd29;
        end

        info.valid = (month inside {[4'd1:4'd12]}) && (day != '0) && (day <= month_len);

        month_off = 10'(days_before(month)) + 10'((leap && month >= 4'd3) ? 1 : 0);
        year_days = SERIAL_W'(year) * SERIAL_W'(365);
        info.serial = year_days + SERIAL_W'(leaps_before) + SERIAL_W'(month_off)
                    + SERIAL_W'(day);
    end

endmodule

// ===== rtl/date_validate_and_day_difference.sv =====
// Top level: two-stage pipeline that checks two dates and reports their day difference.
//
// Usage: each input item on the s_axis channel carries two Gregorian dates
// (day, month, year). Each result item on the m_axis channel reports whether
// each date is a real calendar date, a three-way order of the raw fields
// (year, then month, then day) and the difference of the serial day numbers,
// second minus first, saturated to 23 bits signed.
// Items enter an input register, pass through the date units, the compare and
// the subtract as one combinational pass, and land in the result register.
// A new item can be accepted in every cycle while the result stage is free;
// the rate is one item per cycle while the receiver keeps m_axis_tready high,
// set by the single combinational pass between the two registers.
// When the receiver holds m_axis_tready low, the result register holds its
// item and the input register may still take one more item; after that
// s_axis_tready falls until the receiver drains the result. No item is lost
// or repeated.
// Reset (rst_n low, asynchronous) empties both stages; the block holds no
// other state and is ready for items immediately afterwards.
module date_validate_and_day_difference
    import dvdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: first_day[4:0], first_month[8:5], first_year[22:9],
    // second_day[27:23], second_month[31:28], second_year[45:32], zero [47:46].
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: order[1:0], day_difference[24:2], zero [31:25].
    output logic [31:0] m_axis_tdata,
    // Fields from bit 0: first_valid[0], second_valid[1].
    output logic [1:0]  m_axis_tuser
);

    // Input register stage.
    logic        s1_valid_reg, s1_valid_next;
    logic [45:0] s1_data_reg;
    logic        s1_load;

    // Result register stage.
    logic               s2_valid_reg, s2_valid_next;
    logic               s2_ready;
    logic [ORDER_W-1:0] order_reg, order_next;
    logic [DIFF_W-1:0]  diff_reg, diff_next;
    logic               first_valid_reg, first_valid_next;
    logic               second_valid_reg, second_valid_next;

    logic [DAY_W-1:0]   d1, d2;
    logic [MONTH_W-1:0] m1, m2;
    logic [YEAR_W-1:0]  y1, y2;
    date_info_t         info1, info2;
    logic [SERIAL_W:0]  raw_diff;
    logic [22:0]        key1, key2;

    // The result stage frees up when empty or when its item is taken.
    assign s2_ready      = !s2_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign s1_load       = s_axis_tvalid && s_axis_tready;

    assign d1 = s1_data_reg[4:0];
    assign m1 = s1_data_reg[8:5];
    assign y1 = s1_data_reg[22:9];
    assign d2 = s1_data_reg[27:23];
    assign m2 = s1_data_reg[31:28];
    assign y2 = s1_data_reg[45:32];

    dvdd_date_unit u_first
    (
        .day   (d1),
        .month (m1),
        .year  (y1),
        .info  (info1)
    );

    dvdd_date_unit u_second
    (
        .day   (d2),
        .month (m2),
        .year  (y2),
        .info  (info2)
    );

    always_comb
    begin
        // Lexicographic order on (year, month, day) is a single compare of the
        // concatenated fields.
        key1 = {y1, m1, d1};
        key2 = {y2, m2, d2};
        if (key1 < key2)
        begin
            order_next = ORDER_EARLIER;
        end
        else if (key1 > key2)
        begin
            order_next = ORDER_LATER;
        end
        else
        begin
            order_next = ORDER_EQUAL;
        end

        // Serials are unsigned 23-bit values; the 24-bit difference saturates
        // when its top two bits disagree.
        raw_diff = {1'b0, info2.serial} - {1'b0, info1.serial};
        if (raw_diff[SERIAL_W] != raw_diff[SERIAL_W-1])
        begin
            diff_next = raw_diff[SERIAL_W] ? {1'b1, {(DIFF_W-1){1'b0}}}
                                           : {1'b0, {(DIFF_W-1){1'b1}}};
        end
        else
        begin
            diff_next = raw_diff[DIFF_W-1:0];
        end

        first_valid_next  = info1.valid;
        second_valid_next = info2.valid;

        s1_valid_next = s1_load ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= s_axis_tdata[45:0];
        end
        if (s2_ready && s1_valid_reg)
        begin
            order_reg        <= order_next;
            diff_reg         <= diff_next;
            first_valid_reg  <= first_valid_next;
            second_valid_reg <= second_valid_next;
        end
    end

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = {7'b0, diff_reg, order_reg};
    assign m_axis_tuser  = {second_valid_reg, first_valid_reg};

    // Input is refused only while the input stage holds an item.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> s1_valid_reg)
        else $error("input refused with an empty input stage");

    // Identical dates give a zero difference and matching validity.
    a_equal_zero_diff: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && order_reg == ORDER_EQUAL |->
            diff_reg == '0 && first_valid_reg == second_valid_reg)
        else $error("equal dates with nonzero difference or differing validity");

    // The order code never takes the unused pattern.
    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> order_reg != 2'b10)
        else $error("order code out of range");

    // A result appears only after the input stage held an item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_valid_reg))
        else $error("result appeared without a staged item");

endmodule
